// File: rtl/afr_pkg.sv
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types, register map and CRC-16 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register word indexes (paddr[3:2])
  localparam logic [1:0] REG_NODE_ADDR = 2'd0;
  localparam logic [1:0] REG_CRC_POLY  = 2'd1;
  localparam logic [1:0] REG_CRC_START = 2'd2;

  localparam logic [7:0]  NODE_ADDR_RST = 8'h00;
  localparam logic [15:0] CRC_POLY_RST  = 16'h1021;
  localparam logic [15:0] CRC_START_RST = 16'hFFFF;

  localparam logic [8:0] IDX_ADDR   = 9'd0;
  localparam logic [8:0] IDX_SIZE   = 9'd1;
  localparam logic [8:0] IDX_SOURCE = 9'd2;
  localparam logic [8:0] IDX_PAY0   = 9'd3;
  localparam logic [8:0] IDX_CRCLO0 = 9'd4;

  typedef struct packed {
    logic [7:0]  node_address;
    logic [15:0] crc_polynomial;
    logic [15:0] crc_start;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [8:0] byte_index;
    logic       frame_end;
    logic       crc_ok;
  } res_t;

  typedef enum logic [4:0] {
    PH_WAIT    = 5'b00001,
    PH_SIZE    = 5'b00010,
    PH_SOURCE  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CRCLOW  = 5'b10000
  } phase_t;

  // MSB-first CRC-16 over one byte, implicit top polynomial bit
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[15] ^ data[7-i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ poly;
    end
    return c;
  endfunction

endpackage

// File: rtl/afr_cfg_regs.sv
// ----------------------------------------------------------------------------
// afr_cfg_regs
// APB register file: node address, CRC polynomial, CRC start value.
// ----------------------------------------------------------------------------
module afr_cfg_regs
  import afr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address   <= NODE_ADDR_RST;
      cfg.crc_polynomial <= CRC_POLY_RST;
      cfg.crc_start      <= CRC_START_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NODE_ADDR: cfg.node_address   <= pwdata[7:0];
        REG_CRC_POLY:  cfg.crc_polynomial <= pwdata[15:0];
        REG_CRC_START: cfg.crc_start      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NODE_ADDR: prdata = {24'd0, cfg.node_address};
      REG_CRC_POLY:  prdata = {16'd0, cfg.crc_polynomial};
      REG_CRC_START: prdata = {16'd0, cfg.crc_start};
      default:       prdata = '0;
    endcase
  end

endmodule

// File: rtl/afr_frame_ctl.sv
// ----------------------------------------------------------------------------
// afr_frame_ctl
// Frame phase tracking, running CRC and per-byte result generation.
// ----------------------------------------------------------------------------
module afr_frame_ctl
  import afr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       is_address,
  output logic       res_valid,
  output res_t       res
);

  phase_t      phase, phase_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_high_received, crc_high_received_next;
  logic [15:0] crc_base;
  logic [15:0] crc_upd;
  logic        addr_hit;

  assign addr_hit = is_address && (rx_byte == cfg.node_address);
  assign crc_base = addr_hit ? cfg.crc_start : running_crc;
  assign crc_upd  = crc16_byte(crc_base, rx_byte, cfg.crc_polynomial);

  always_comb begin
    phase_next             = phase;
    payload_length_next    = payload_length;
    payload_count_next     = payload_count;
    running_crc_next       = running_crc;
    crc_high_received_next = crc_high_received;
    res_valid              = 1'b0;
    res.frame_byte         = rx_byte;
    res.byte_index         = IDX_ADDR;
    res.frame_end          = 1'b0;
    res.crc_ok             = 1'b0;
    if (is_address) begin
      // foreign address: no result, state untouched
      if (addr_hit) begin
        running_crc_next = crc_upd;
        phase_next       = PH_SIZE;
        res_valid        = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_SIZE: begin
          running_crc_next    = crc_upd;
          payload_length_next = rx_byte;
          payload_count_next  = 8'd0;
          phase_next          = PH_SOURCE;
          res_valid           = 1'b1;
          res.byte_index      = IDX_SIZE;
        end
        PH_SOURCE: begin
          running_crc_next = crc_upd;
          phase_next       = PH_PAYLOAD;
          res_valid        = 1'b1;
          res.byte_index   = IDX_SOURCE;
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          if (payload_count < payload_length) begin
            running_crc_next   = crc_upd;
            res.byte_index     = IDX_PAY0 + {1'b0, payload_count};
            payload_count_next = payload_count + 8'd1;
          end else begin
            crc_high_received_next = rx_byte;
            phase_next             = PH_CRCLOW;
            res.byte_index         = IDX_PAY0 + {1'b0, payload_length};
          end
        end
        PH_CRCLOW: begin
          phase_next     = PH_WAIT;
          res_valid      = 1'b1;
          res.byte_index = IDX_CRCLO0 + {1'b0, payload_length};
          res.frame_end  = 1'b1;
          res.crc_ok     = (crc_high_received == running_crc[15:8]) &&
                           (rx_byte == running_crc[7:0]);
        end
        default: phase_next = PH_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_WAIT;
      payload_length    <= 8'd0;
      payload_count     <= 8'd0;
      running_crc       <= 16'd0;
      crc_high_received <= 8'd0;
    end else if (accept) begin
      phase             <= phase_next;
      payload_length    <= payload_length_next;
      payload_count     <= payload_count_next;
      running_crc       <= running_crc_next;
      crc_high_received <= crc_high_received_next;
    end
  end

  a_addr_starts_frame: assert property (@(posedge clk) disable iff (rst)
    accept && addr_hit |=> phase == PH_SIZE)
    else $error("matching address did not start a frame");

  a_idle_data_silent: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_address |-> phase != PH_WAIT)
    else $error("data byte produced a result while waiting for address");

  a_end_from_crclow: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && res.frame_end |=> phase == PH_WAIT)
    else $error("frame end did not return to address wait");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (rst)
    res.crc_ok |-> res.frame_end)
    else $error("crc_ok raised outside frame end");

endmodule

// File: rtl/afr_out_buf.sv
// ----------------------------------------------------------------------------
// afr_out_buf
// Output register plus skid stage; input ready depends only on local state.
// ----------------------------------------------------------------------------
module afr_out_buf
  import afr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  res_t in_res,
  output logic space,
  output logic out_valid,
  output res_t out_res,
  input  logic out_ready
);

  logic skid_valid;
  res_t skid_res;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_valid ? skid_res : in_res;
    end else if (in_valid && !skid_valid) begin
      skid_res <= in_res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled without an output stall");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> !skid_valid && out_valid)
    else $error("skid beat not moved to output");

endmodule

// File: rtl/addressed_frame_receiver_crc16_top.sv
// ----------------------------------------------------------------------------
// addressed_frame_receiver_crc16_top
// Multidrop bus frame receiver with address filter and CRC-16 check.
// ----------------------------------------------------------------------------
// Input stream: one received character per beat, s_tdata = rx_byte,
// s_tuser = address flag (ninth bit). Output stream: one beat per byte that
// belongs to a frame for this node, m_tdata = {byte_index, frame_byte},
// m_tlast marks the CRC low byte, m_tuser carries crc_ok with it.
// Foreign addresses and data seen while waiting for an address give no beat.
// Throughput: one character per cycle while s_tready is high. The CRC byte
// update is an unrolled eight-step XOR network ahead of the state registers,
// so each accepted beat updates the frame state in its own cycle. Results
// are registered in the output stage before they appear on m_*.
// A two-entry output stage (register plus skid) decouples the sides;
// s_tready drops only when both entries are full, i.e. after the receiver
// has stalled with a beat pending and another one arrived.
// Reset (synchronous, rst high) returns the filter to waiting for an
// address, empties the output stage and loads the register defaults:
// node address 0x00, polynomial 0x1021, start value 0xFFFF.
// Registers over APB: 0x0 node address, 0x4 polynomial, 0x8 start value.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_crc16_top
  import afr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // APB
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_byte
  input  logic               s_tuser,   // [0] is_address
  // output stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,   // [7:0] frame_byte, [16:8] byte_index, zero pad
  output logic               m_tlast,
  output logic               m_tuser    // [0] crc_ok
);

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic accept;
  logic space;

  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;

  afr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afr_frame_ctl u_ctl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .rx_byte    (s_tdata),
    .is_address (s_tuser),
    .res_valid  (res_valid),
    .res        (res)
  );

  afr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && res_valid),
    .in_res    (res),
    .space     (space),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {7'd0, out_res.byte_index, out_res.frame_byte};
  assign m_tlast = out_res.frame_end;
  assign m_tuser = out_res.crc_ok;

endmodule
